// ===== rtl/tfp_pkg.sv =====
// Track frame parser: shared constants, character codes, register indexes and types.
// Used by tfp_parser, tfp_result and track_frame_parser. No dependencies.
`default_nettype none

package tfp_pkg;

  // Field value width default and range limits
  localparam int VALUE_BITS_DEF = 16;
  localparam int NUM_FIELDS     = 6;
  localparam int FIDX_W         = 3;

  // Fixed widths of registers and result fields
  localparam int CMD_W    = 16;
  localparam int LEN_W    = 8;
  localparam int CENTER_W = 17;
  localparam int BOX_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 72;

  localparam logic [CENTER_W-1:0] CENTER_MAX = 17'd98302;
  localparam logic [BOX_W-1:0]    BOX_MAX    = 16'hFFFF;
  localparam logic [LEN_W-1:0]    LEN_MAX    = 8'hFF;

  // Register reset values
  localparam logic [CMD_W-1:0] CMD_RST     = 16'd23;
  localparam logic [CMD_W-1:0] SUBCMD_RST  = 16'd6;
  localparam logic [LEN_W-1:0] MIN_LEN_RST = 8'd14;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CMD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBCMD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 2'd2;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CMD_W-1:0] subcmd;
    logic [LEN_W-1:0] min_len;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_BODY = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    SUB_FRESH  = 3'b001,
    SUB_SPACES = 3'b010,
    SUB_DIGITS = 3'b100
  } sub_t;

endpackage

`default_nettype wire

// ===== rtl/tfp_parser.sv =====
// Track frame parser: frame state machine, field accumulator and field store,
// with the request register towards the result stage. Depends on tfp_pkg.
`default_nettype none

module tfp_parser #(
  parameter int VALUE_BITS = tfp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tfp_pkg::cfg_t               cfg,
  input  wire logic                        item_valid,
  input  wire logic [tfp_pkg::BYTE_W-1:0]  item_byte,
  input  wire logic                        item_last,
  output logic                             item_take,
  output logic                             req_valid,
  input  wire logic                        req_ready,
  output logic                             req_accepted,
  output logic [VALUE_BITS-1:0]            req_x,
  output logic [VALUE_BITS-1:0]            req_y,
  output logic [VALUE_BITS-1:0]            req_w,
  output logic [VALUE_BITS-1:0]            req_h
);

  localparam int CW = (VALUE_BITS > tfp_pkg::CMD_W) ? VALUE_BITS : tfp_pkg::CMD_W;
  localparam int PW = VALUE_BITS + 4;
  localparam logic [tfp_pkg::FIDX_W-1:0] FIDX_FULL = tfp_pkg::FIDX_W'(tfp_pkg::NUM_FIELDS);
  localparam logic [tfp_pkg::FIDX_W-1:0] FIDX_LAST = tfp_pkg::FIDX_W'(tfp_pkg::NUM_FIELDS - 1);

  tfp_pkg::phase_t                 phase_r, phase_nxt;
  tfp_pkg::sub_t                   sub_r, sub_nxt;
  logic [tfp_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [tfp_pkg::FIDX_W-1:0]      fidx_r, fidx_nxt;
  logic [VALUE_BITS-1:0]           acc_r, acc_nxt;
  logic [VALUE_BITS-1:0]           fields_r [tfp_pkg::NUM_FIELDS];

  logic                            req_v_r, req_v_nxt;
  logic                            req_acc_r;
  logic [VALUE_BITS-1:0]           req_x_r, req_y_r, req_w_r, req_h_r;

  logic                            is_digit, is_comma, is_space, is_hash, is_dollar;
  logic [3:0]                      dval;
  logic [PW-1:0]                   acc_ext, prod;
  logic [VALUE_BITS-1:0]           acc_mac;
  logic                            do_store, do_fill;
  logic [VALUE_BITS-1:0]           st_val;
  logic [tfp_pkg::NUM_FIELDS-1:0]  fld_we;
  logic [VALUE_BITS-1:0]           fld_wd [tfp_pkg::NUM_FIELDS];

  logic [tfp_pkg::LEN_W-1:0]       len_fin;
  logic [VALUE_BITS-1:0]           f5_fin;
  logic                            six_fin, ok_fin;
  logic                            fire, fire_ok, req_free;

  always_comb begin
    is_digit  = (item_byte >= tfp_pkg::CHAR_ZERO) && (item_byte <= tfp_pkg::CHAR_NINE);
    is_comma  = (item_byte == tfp_pkg::CHAR_COMMA);
    is_space  = (item_byte == tfp_pkg::CHAR_SPACE);
    is_hash   = (item_byte == tfp_pkg::CHAR_HASH);
    is_dollar = (item_byte == tfp_pkg::CHAR_DOLLAR);
    dval      = item_byte[3:0] - tfp_pkg::CHAR_ZERO[3:0];

    // acc * 10 + digit, saturating at the top of the value range
    acc_ext = PW'(acc_r);
    prod    = (acc_ext << 3) + (acc_ext << 1) + PW'(dval);
    acc_mac = (|prod[PW-1:VALUE_BITS]) ? '1 : prod[VALUE_BITS-1:0];
  end

  // Closing marker: flush a pending field and judge the frame
  always_comb begin
    len_fin = (len_r == tfp_pkg::LEN_MAX) ? tfp_pkg::LEN_MAX : len_r + 1'b1;
    six_fin = (fidx_r == FIDX_FULL) || ((fidx_r == FIDX_LAST) && (sub_r != tfp_pkg::SUB_FRESH));
    f5_fin  = fields_r[tfp_pkg::NUM_FIELDS-1];
    if (fidx_r == FIDX_LAST) begin
      f5_fin = (sub_r == tfp_pkg::SUB_DIGITS) ? acc_r : '0;
    end
    ok_fin = six_fin && (len_fin >= cfg.min_len) &&
             (CW'(fields_r[0]) == CW'(cfg.cmd)) &&
             (CW'(fields_r[1]) == CW'(cfg.subcmd));
  end

  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    len_nxt   = len_r;
    fidx_nxt  = fidx_r;
    acc_nxt   = acc_r;
    do_store  = 1'b0;
    do_fill   = 1'b0;
    st_val    = '0;
    fire      = 1'b0;
    fire_ok   = 1'b0;

    unique case (phase_r)
      tfp_pkg::PH_HUNT: begin
        if (is_dollar) begin
          len_nxt   = tfp_pkg::LEN_W'(1);
          fidx_nxt  = '0;
          sub_nxt   = tfp_pkg::SUB_FRESH;
          acc_nxt   = '0;
          phase_nxt = tfp_pkg::PH_BODY;
        end
      end
      tfp_pkg::PH_BODY: begin
        if (is_hash) begin
          fire      = 1'b1;
          fire_ok   = ok_fin;
          phase_nxt = tfp_pkg::PH_DONE;
        end else begin
          if (len_r != tfp_pkg::LEN_MAX) begin
            len_nxt = len_r + 1'b1;
          end
          if (fidx_r != FIDX_FULL) begin
            if (sub_r == tfp_pkg::SUB_DIGITS) begin
              if (is_digit) begin
                acc_nxt = acc_mac;
              end else begin
                do_store = 1'b1;
                st_val   = acc_r;
                if (is_comma) begin
                  sub_nxt = tfp_pkg::SUB_FRESH;
                end else if (is_space) begin
                  sub_nxt = tfp_pkg::SUB_SPACES;
                end else begin
                  do_fill = 1'b1;
                end
              end
            end else begin
              if (is_space) begin
                sub_nxt = tfp_pkg::SUB_SPACES;
              end else if (is_digit) begin
                acc_nxt = VALUE_BITS'(dval);
                sub_nxt = tfp_pkg::SUB_DIGITS;
              end else if (is_comma) begin
                do_store = 1'b1;
                sub_nxt  = tfp_pkg::SUB_FRESH;
              end else begin
                do_fill = 1'b1;
              end
            end
            if (do_fill) begin
              fidx_nxt = FIDX_FULL;
            end else if (do_store) begin
              fidx_nxt = fidx_r + 1'b1;
            end
          end
        end
      end
      tfp_pkg::PH_DONE: begin
        // drop bytes until the buffer ends
      end
      default: begin
        phase_nxt = tfp_pkg::PH_HUNT;
      end
    endcase

    // End of buffer: reject if no frame was closed, then rearm
    if (item_last) begin
      if (phase_nxt != tfp_pkg::PH_DONE) begin
        fire    = 1'b1;
        fire_ok = 1'b0;
      end
      phase_nxt = tfp_pkg::PH_HUNT;
      len_nxt   = '0;
      fidx_nxt  = '0;
      sub_nxt   = tfp_pkg::SUB_FRESH;
      acc_nxt   = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < tfp_pkg::NUM_FIELDS; i++) begin
      fld_we[i] = (do_store && (tfp_pkg::FIDX_W'(i) == fidx_r)) ||
                  (do_fill && (tfp_pkg::FIDX_W'(i) >= fidx_r));
      fld_wd[i] = (do_store && (tfp_pkg::FIDX_W'(i) == fidx_r)) ? st_val : '0;
    end
  end

  assign req_free  = !req_v_r || req_ready;
  assign item_take = item_valid && (!fire || req_free);

  always_comb begin
    req_v_nxt = req_v_r;
    if (item_take && fire) begin
      req_v_nxt = 1'b1;
    end else if (req_ready) begin
      req_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tfp_pkg::PH_HUNT;
      sub_r   <= tfp_pkg::SUB_FRESH;
      len_r   <= '0;
      fidx_r  <= '0;
      acc_r   <= '0;
      req_v_r <= 1'b0;
    end else begin
      req_v_r <= req_v_nxt;
      if (item_take) begin
        phase_r <= phase_nxt;
        sub_r   <= sub_nxt;
        len_r   <= len_nxt;
        fidx_r  <= fidx_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < tfp_pkg::NUM_FIELDS; i++) begin
      if (item_take && fld_we[i]) begin
        fields_r[i] <= fld_wd[i];
      end
    end
    if (item_take && fire) begin
      req_acc_r <= fire_ok;
      req_x_r   <= fields_r[2];
      req_y_r   <= fields_r[3];
      req_w_r   <= fields_r[4];
      req_h_r   <= f5_fin;
    end
  end

  assign req_valid    = req_v_r;
  assign req_accepted = req_acc_r;
  assign req_x        = req_x_r;
  assign req_y        = req_y_r;
  assign req_w        = req_w_r;
  assign req_h        = req_h_r;

endmodule

`default_nettype wire

// ===== rtl/tfp_result.sv =====
// Track frame parser: box centre arithmetic, saturation and output register.
// Depends on tfp_pkg; fed by tfp_parser.
`default_nettype none

module tfp_result #(
  parameter int VALUE_BITS = tfp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire logic                              req_accepted,
  input  wire logic [VALUE_BITS-1:0]             req_x,
  input  wire logic [VALUE_BITS-1:0]             req_y,
  input  wire logic [VALUE_BITS-1:0]             req_w,
  input  wire logic [VALUE_BITS-1:0]             req_h,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_accepted,
  output logic [tfp_pkg::CENTER_W-1:0]           out_cx,
  output logic [tfp_pkg::CENTER_W-1:0]           out_cy,
  output logic [tfp_pkg::BOX_W-1:0]              out_w,
  output logic [tfp_pkg::BOX_W-1:0]              out_h
);

  localparam int CXW = (VALUE_BITS + 1 > tfp_pkg::CENTER_W) ? VALUE_BITS + 1 : tfp_pkg::CENTER_W;
  localparam int BW  = (VALUE_BITS > tfp_pkg::BOX_W) ? VALUE_BITS : tfp_pkg::BOX_W;

  logic                          out_v_r, out_v_nxt;
  logic                          acc_r;
  logic [tfp_pkg::CENTER_W-1:0]  cx_r, cy_r, cx_nxt, cy_nxt;
  logic [tfp_pkg::BOX_W-1:0]     w_r, h_r, w_nxt, h_nxt;
  logic [CXW-1:0]                sum_x, sum_y;
  logic [BW-1:0]                 w_ext, h_ext;
  logic                          load;

  always_comb begin
    sum_x = CXW'(req_x) + CXW'(req_w >> 1);
    sum_y = CXW'(req_y) + CXW'(req_h >> 1);
    w_ext = BW'(req_w);
    h_ext = BW'(req_h);

    cx_nxt = (sum_x > CXW'(tfp_pkg::CENTER_MAX)) ? tfp_pkg::CENTER_MAX
                                                  : sum_x[tfp_pkg::CENTER_W-1:0];
    cy_nxt = (sum_y > CXW'(tfp_pkg::CENTER_MAX)) ? tfp_pkg::CENTER_MAX
                                                  : sum_y[tfp_pkg::CENTER_W-1:0];
    w_nxt  = (w_ext > BW'(tfp_pkg::BOX_MAX)) ? tfp_pkg::BOX_MAX : w_ext[tfp_pkg::BOX_W-1:0];
    h_nxt  = (h_ext > BW'(tfp_pkg::BOX_MAX)) ? tfp_pkg::BOX_MAX : h_ext[tfp_pkg::BOX_W-1:0];

    // rejected frames carry an all-zero box
    if (!req_accepted) begin
      cx_nxt = '0;
      cy_nxt = '0;
      w_nxt  = '0;
      h_nxt  = '0;
    end
  end

  assign req_ready = !out_v_r || out_ready;
  assign load      = req_valid && req_ready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= req_accepted;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      w_r   <= w_nxt;
      h_r   <= h_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_accepted = acc_r;
  assign out_cx       = cx_r;
  assign out_cy       = cy_r;
  assign out_w        = w_r;
  assign out_h        = h_r;

endmodule

`default_nettype wire

// ===== rtl/track_frame_parser.sv =====
// Track frame parser top level: 1 byte per cycle, back to back, unless a closing
// byte waits for the result path. A byte is held in the input register and then
// handled by the frame state machine; a result request waits in the request
// register and is then loaded into the output register that drives out_tvalid.
// rst_n is synchronous, active low: registers go to their reset values, the parser
// hunts for a start marker and all pipeline stages are emptied.
// Depends on tfp_pkg, tfp_parser and tfp_result.
`default_nettype none

module track_frame_parser #(
  parameter int VALUE_BITS = tfp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration write port
  input  wire logic                               cfg_wr_en,
  input  wire logic [tfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tfp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  wire logic                               in_tlast,   // buffer_end
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [16:0] center_x, [33:17] center_y, [49:34] box_width, [65:50] box_height,
  // [71:66] zero
  output logic [tfp_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                    out_tuser   // accepted
);

  tfp_pkg::cfg_t                   cfg_r;
  logic                            in_v_r, in_v_nxt;
  logic [tfp_pkg::BYTE_W-1:0]      byte_r;
  logic                            last_r;
  logic                            item_take;

  logic                            req_valid, req_ready, req_accepted;
  logic [VALUE_BITS-1:0]           req_x, req_y, req_w, req_h;

  logic [tfp_pkg::CENTER_W-1:0]    res_cx, res_cy;
  logic [tfp_pkg::BOX_W-1:0]       res_w, res_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd     <= tfp_pkg::CMD_RST;
      cfg_r.subcmd  <= tfp_pkg::SUBCMD_RST;
      cfg_r.min_len <= tfp_pkg::MIN_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tfp_pkg::REG_CMD:     cfg_r.cmd     <= cfg_wdata[tfp_pkg::CMD_W-1:0];
        tfp_pkg::REG_SUBCMD:  cfg_r.subcmd  <= cfg_wdata[tfp_pkg::CMD_W-1:0];
        tfp_pkg::REG_MIN_LEN: cfg_r.min_len <= cfg_wdata[tfp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: refill in the same cycle the parser takes the held byte
  assign in_tready = !in_v_r || item_take;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (item_take) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  tfp_parser #(
    .VALUE_BITS (VALUE_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .item_valid   (in_v_r),
    .item_byte    (byte_r),
    .item_last    (last_r),
    .item_take    (item_take),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_accepted (req_accepted),
    .req_x        (req_x),
    .req_y        (req_y),
    .req_w        (req_w),
    .req_h        (req_h)
  );

  tfp_result #(
    .VALUE_BITS (VALUE_BITS)
  ) u_result (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_accepted (req_accepted),
    .req_x        (req_x),
    .req_y        (req_y),
    .req_w        (req_w),
    .req_h        (req_h),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_accepted (out_tuser),
    .out_cx       (res_cx),
    .out_cy       (res_cy),
    .out_w        (res_w),
    .out_h        (res_h)
  );

  assign out_tdata = {6'b0, res_h, res_w, res_cy, res_cx};

  // A held input byte is never overwritten before the parser takes it
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !item_take |=> in_v_r && $stable(byte_r) && $stable(last_r))
    else $error("input register overwritten");

  // A rejected frame carries an all-zero box
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("rejected result with non-zero fields");

  // Centres stay within their saturation limit
  a_center_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:0] <= tfp_pkg::CENTER_MAX) &&
                   (out_tdata[33:17] <= tfp_pkg::CENTER_MAX))
    else $error("centre beyond saturation limit");

  // A request is only raised by a byte the parser took
  a_req_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(req_valid) |-> $past(item_take))
    else $error("request raised without a taken byte");

endmodule

`default_nettype wire
